FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the header converter.
// No dependencies; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WTEC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define WTEC_NEVER(lbl, clk, rst_n, expr) \
  `WTEC_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define WTEC_ASSERT(lbl, clk, rst_n, prop)
`define WTEC_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: rtl/core/wtec_pkg.sv
// Types and constants of the 802.11 to Ethernet II header converter.
// No dependencies.
`timescale 1ns / 1ps
package wtec_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Address beats ahead of the first kept byte.
  localparam logic [3:0] HDR_BEATS = 4'd12;
  localparam logic [5:0] POS_MAX   = 6'd63;

  typedef enum logic [1:0] {
    CMD_PASS = 2'd0,
    CMD_HDR  = 2'd1,
    CMD_ERR  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic        last;
    logic [47:0] dst;
    logic [47:0] src;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: rtl/core/wtec_front.sv
// Front end: accepts 802.11 bytes, tracks header position, captures addresses
// and issues commands to the queue. Depends on wtec_pkg.
`timescale 1ns / 1ps
module wtec_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pass_through_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  input  wtec_pkg::fifo_stat_t stat_i,
  output logic               push_o,
  output wtec_pkg::cmd_t     cmd_o
);

  logic [5:0]  pos_q, pos_d;
  logic [1:0]  ds_q, ds_d;
  logic        qos_q, qos_d;
  logic [47:0] dst_q, dst_d;
  logic [47:0] src_q, src_d;
  logic        payload_q, payload_d;

  logic        accept;
  logic [1:0]  ds_eff;
  logic        qos_eff;
  logic [5:0]  dst_at, src_at, hdr_len;

  assign in_ready_o = !stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ds_eff  = (pos_q == 6'd1) ? in_byte_i[1:0] : ds_q;
    qos_eff = (pos_q == 6'd0) ? in_byte_i[7] : qos_q;
    dst_at  = ds_eff[0] ? 6'd16 : 6'd4;
    unique case (ds_eff)
      2'd0, 2'd1: src_at = 6'd10;
      2'd2:       src_at = 6'd16;
      default:    src_at = 6'd24;
    endcase
    hdr_len = ((ds_eff == 2'd3) ? 6'd30 : 6'd24) + (qos_eff ? 6'd2 : 6'd0) + 6'd6;
  end

  always_comb begin
    pos_d     = pos_q;
    ds_d      = ds_q;
    qos_d     = qos_q;
    dst_d     = dst_q;
    src_d     = src_q;
    payload_d = payload_q;
    push_o    = 1'b0;
    cmd_o     = '{kind: wtec_pkg::CMD_PASS, data: in_byte_i, last: in_last_i,
                  dst: dst_q, src: src_q};
    if (accept) begin
      if (pass_through_i || payload_q) begin
        push_o = 1'b1;
      end else begin
        ds_d  = ds_eff;
        qos_d = qos_eff;
        if (pos_q >= 6'd2 && pos_q >= dst_at && pos_q < dst_at + 6'd6) begin
          dst_d = {dst_q[39:0], in_byte_i};
        end
        if (pos_q >= 6'd2 && pos_q >= src_at && pos_q < src_at + 6'd6) begin
          src_d = {src_q[39:0], in_byte_i};
        end
        cmd_o.dst = dst_d;
        cmd_o.src = src_d;
        priority if (pos_q >= hdr_len) begin
          // first kept byte: queue the address burst along with it
          push_o     = 1'b1;
          cmd_o.kind = wtec_pkg::CMD_HDR;
          payload_d  = 1'b1;
        end else if (in_last_i) begin
          push_o     = 1'b1;
          cmd_o.kind = wtec_pkg::CMD_ERR;
          cmd_o.data = 8'd0;
        end else if (pos_q < wtec_pkg::POS_MAX) begin
          pos_d = pos_q + 6'd1;
        end
      end
      if (in_last_i) begin
        pos_d     = '0;
        ds_d      = '0;
        qos_d     = 1'b0;
        dst_d     = '0;
        src_d     = '0;
        payload_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      ds_q      <= '0;
      qos_q     <= 1'b0;
      dst_q     <= '0;
      src_q     <= '0;
      payload_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      ds_q      <= ds_d;
      qos_q     <= qos_d;
      dst_q     <= dst_d;
      src_q     <= src_d;
      payload_q <= payload_d;
    end
  end

endmodule

FILE: rtl/core/wtec_fifo.sv
// Short command queue between front and back end.
// Depends on wtec_pkg.
`timescale 1ns / 1ps
module wtec_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  wtec_pkg::cmd_t       cmd_i,
  input  logic                 pop_i,
  output wtec_pkg::cmd_t       head_o,
  output wtec_pkg::fifo_stat_t stat_o
);

  wtec_pkg::cmd_t mem_q [wtec_pkg::FIFO_DEPTH];
  logic [wtec_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [wtec_pkg::FIFO_CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  function automatic logic [wtec_pkg::FIFO_CNT_W-1:0] FIFO_CNT_W_one(input logic b);
    return {{(wtec_pkg::FIFO_CNT_W-1){1'b0}}, b};
  endfunction

  assign stat_o.full  = (cnt_q == wtec_pkg::FIFO_CNT_W'(wtec_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + FIFO_CNT_W_one(do_push) - FIFO_CNT_W_one(do_pop);
    end
  end

endmodule

FILE: rtl/core/wtec_back.sv
// Back end: plays queued commands out as output beats, expanding a header
// command into twelve address beats and the kept byte. Depends on wtec_pkg.
`timescale 1ns / 1ps
module wtec_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wtec_pkg::cmd_t       head_i,
  input  wtec_pkg::fifo_stat_t stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic                 too_short_o
);

  logic [3:0]  beat_q, beat_d;
  logic [2:0]  idx;
  logic [2:0]  lane;
  logic [47:0] mac;
  logic        fire;
  logic        final_beat;

  assign out_valid_o = !stat_i.empty;
  assign fire        = out_valid_o && out_ready_i;

  always_comb begin
    mac  = (beat_q < 4'd6) ? head_i.dst : head_i.src;
    idx  = (beat_q < 4'd6) ? beat_q[2:0] : 3'(beat_q - 4'd6);
    lane = 3'd5 - idx;
    out_byte_o  = head_i.data;
    out_last_o  = head_i.last;
    too_short_o = 1'b0;
    final_beat  = 1'b1;
    unique case (head_i.kind)
      wtec_pkg::CMD_PASS: begin
      end
      wtec_pkg::CMD_HDR: begin
        if (beat_q != wtec_pkg::HDR_BEATS) begin
          out_byte_o = mac[{lane, 3'b000} +: 8];
          out_last_o = 1'b0;
          final_beat = 1'b0;
        end
      end
      wtec_pkg::CMD_ERR: begin
        out_byte_o  = 8'd0;
        out_last_o  = 1'b1;
        too_short_o = 1'b1;
      end
      default: begin
      end
    endcase
    pop_o  = fire && final_beat;
    beat_d = beat_q;
    if (fire) begin
      beat_d = final_beat ? 4'd0 : beat_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

endmodule

FILE: rtl/core/wlan_to_ethernet_header_convert_core.sv
// Top level of the 802.11 data frame to Ethernet II converter.
// Depends on wtec_pkg, wtec_front, wtec_fifo, wtec_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Converts a byte stream of 802.11 data frames (FCS removed) into Ethernet II
// frames: the header, QoS field and first six LLC/SNAP bytes are dropped, and
// destination and source addresses chosen by ToDS/FromDS are emitted ahead of
// the ethertype. Setting pass_through copies bytes unchanged. A frame that ends
// inside the stripped header yields one beat with too_short set and data zero.
// Throughput is one input byte per cycle unless the queue is full; stripped
// header bytes produce no output. The first kept byte of each frame expands
// into 13 output beats in the back end, so while that burst drains the four-entry
// command queue fills and, with the output never stalled and more than three
// payload bytes behind the ethertype, input stalls once per converted frame.
module wlan_to_ethernet_header_convert_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       too_short_o
);

  logic                 pass_through_q;
  logic                 push;
  logic                 pop;
  wtec_pkg::cmd_t       cmd;
  wtec_pkg::cmd_t       head;
  wtec_pkg::fifo_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_through_q <= 1'b0;
    end else if (cfg_we_i) begin
      pass_through_q <= cfg_data_i;
    end
  end

  wtec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pass_through_i(pass_through_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .stat_i        (stat),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  wtec_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .cmd_i (cmd),
    .pop_i (pop),
    .head_o(head),
    .stat_o(stat)
  );

  wtec_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .stat_i     (stat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .too_short_o(too_short_o)
  );

  `WTEC_ASSERT(a_short_is_last, clk_i, rst_ni, (out_valid_o && too_short_o) |-> (out_last_o && out_byte_o == 8'd0))
  `WTEC_NEVER(a_full_and_empty, clk_i, rst_ni, stat.full && stat.empty)
  `WTEC_ASSERT(a_stall_only_full, clk_i, rst_ni, (in_valid_i && !in_ready_o) |-> stat.full)

endmodule

FILE: tb/tb_wlan_to_ethernet_header_convert_core.sv
// Self-checking testbench for wlan_to_ethernet_header_convert_core: 802.11 byte
// frames in, predicted Ethernet II beats checked in order on the output side.
// Depends only on the RTL of the converter.
`timescale 1ns / 1ps
module tb_wlan_to_ethernet_header_convert_core;

  localparam int DRAIN_CYCLES  = 24;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_BYTES   = 70;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       out_last_o;
  logic       too_short_o;

  int          in_idle_pct;
  int          out_idle_pct;
  int unsigned bytes_sent;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       short_err;
  } eth_beat_t;

  class eth_frame_scoreboard;
    bit          pass_through;
    int unsigned hdr_pos;
    logic [1:0]  ds_bits;
    logic        qos;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    bit          in_payload;
    eth_beat_t   expected_beats[$];
    int unsigned errors;

    function new();
      pass_through = 1'b0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      hdr_pos = 0;
      ds_bits = 2'd0;
      qos = 1'b0;
      dst_mac = '0;
      src_mac = '0;
      in_payload = 1'b0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void push_beat(logic [7:0] d, logic l, logic e);
      eth_beat_t x;
      x.data = d;
      x.last = l;
      x.short_err = e;
      expected_beats.push_back(x);
    endfunction

    // Predict the output beats caused by one accepted input byte.
    function void note_byte(logic [7:0] b, logic l);
      int unsigned p;
      int unsigned dst_at;
      int unsigned src_at;
      int unsigned hdr_len;
      int i;
      if (pass_through || in_payload) begin
        push_beat(b, l, 1'b0);
      end else begin
        p = hdr_pos;
        if (p == 0) qos = b[7];
        if (p == 1) ds_bits = b[1:0];
        dst_at = ds_bits[0] ? 16 : 4;
        case (ds_bits)
          2'd2:    src_at = 16;
          2'd3:    src_at = 24;
          default: src_at = 10;
        endcase
        hdr_len = (ds_bits == 2'd3 ? 30 : 24) + (qos ? 2 : 0) + 6;
        if (p >= 2 && p >= dst_at && p < dst_at + 6) dst_mac = {dst_mac[39:0], b};
        if (p >= 2 && p >= src_at && p < src_at + 6) src_mac = {src_mac[39:0], b};
        if (p >= hdr_len) begin
          // first kept byte: address burst, then the byte itself
          for (i = 0; i < 6; i++) push_beat(dst_mac[47 - 8 * i -: 8], 1'b0, 1'b0);
          for (i = 0; i < 6; i++) push_beat(src_mac[47 - 8 * i -: 8], 1'b0, 1'b0);
          push_beat(b, l, 1'b0);
          in_payload = 1'b1;
        end else if (l) begin
          push_beat(8'h00, 1'b1, 1'b1);
        end else if (hdr_pos < 63) begin
          hdr_pos++;
        end
      end
      if (l) clear_frame();
    endfunction

    function void check_beat(logic [7:0] d, logic l, logic e);
      eth_beat_t x;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, actual byte %h last %b too_short %b",
                 $time, d, l, e);
        return;
      end
      x = expected_beats.pop_front();
      if (x.data !== d) begin
        errors++;
        $display("%0t: out_byte mismatch: expected %h, actual %h", $time, x.data, d);
      end
      if (x.last !== l) begin
        errors++;
        $display("%0t: out_last mismatch: expected %b, actual %b", $time, x.last, l);
      end
      if (x.short_err !== e) begin
        errors++;
        $display("%0t: too_short mismatch: expected %b, actual %b", $time, x.short_err, e);
      end
    endfunction
  endclass

  eth_frame_scoreboard sb;

  wlan_to_ethernet_header_convert_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .too_short_o (too_short_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Note accepted input beats before checking output beats of the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(in_byte_i, in_last_i);
      if (out_valid_o && out_ready_i) sb.check_beat(out_byte_o, out_last_o, too_short_o);
    end
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Drain the block fully before touching the mode register.
  task automatic write_pass_through(input logic v);
    in_valid_i <= 1'b0;
    // let the last accepted beat reach the scoreboard first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.pass_through = v;
  endtask

  // Mostly well-formed frames, some cut short inside the header, some noise.
  task automatic send_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned hdr_len;
    int unsigned i;
    logic [1:0]  ds;
    logic        qos;
    logic [7:0]  b;
    kind = $urandom_range(99);
    ds = 2'($urandom_range(3));
    qos = 1'($urandom_range(1));
    hdr_len = (ds == 2'd3 ? 30 : 24) + (qos ? 2 : 0) + 6;
    if (kind < 75) len = hdr_len + 1 + $urandom_range(8);
    else if (kind < 90) len = $urandom_range(hdr_len, 1);
    else len = $urandom_range(48, 1);
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (kind < 90) begin
        if (i == 0) b[7] = qos;
        if (i == 1) b[1:0] = ds;
      end
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic run_phase(input int in_pct, input int out_pct);
    int unsigned start;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) begin
      if ($urandom_range(5) == 0) write_pass_through(1'($urandom_range(1)));
      send_frame();
    end
  endtask

  initial begin
    sb = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = 1'b0;
    in_valid_i   = 1'b0;
    in_byte_i    = 8'h00;
    in_last_i    = 1'b0;
    out_ready_i  = 1'b0;
    in_idle_pct  = 17;
    out_idle_pct = 56;
    bytes_sent   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pass-through copies bytes and last as they are.
    write_pass_through(1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b1);
    // Frames that end inside the stripped header.
    write_pass_through(1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h08, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h7E, 1'b1);
    // Mode flips in mid-frame: pass-through bytes leave the header count alone.
    send_byte(8'h88, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h3C, 1'b0);
    write_pass_through(1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h00, 1'b0);
    write_pass_through(1'b0);
    send_byte(8'hE1, 1'b0);
    send_byte(8'h1F, 1'b1);
    // A last beat taken in pass-through still clears the framing state.
    send_byte(8'h80, 1'b0);
    write_pass_through(1'b1);
    send_byte(8'hAA, 1'b1);
    write_pass_through(1'b0);

    run_phase(17, 56);
    run_phase(56, 17);
    run_phase(0, 0);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
